// ----- rtl/core/id3_pkg.sv -----
// Shared types and constants for the ID3v2 frame extractor.
package id3_pkg;

  // Field widths of the byte stream and of the result stream, and counter widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdW    = 32;
  localparam int unsigned CountW = 28;
  localparam int unsigned RemW   = 30;
  localparam int unsigned OutW   = IdW + ByteW;

  // Configuration register indexes.
  localparam logic CfgSelectMode = 1'b0;
  localparam logic CfgSearchId   = 1'b1;

  // Flag bit in the tag header that announces an extended header.
  localparam logic [ByteW-1:0] ExtHeaderFlag = 8'h40;

  // Frame id that show-all mode never selects.
  localparam logic [IdW-1:0] IdApic = 32'h41504943;

  // Range of first id characters accepted in show-all mode.
  localparam logic [ByteW-1:0] IdFirstLow  = 8'd65;
  localparam logic [ByteW-1:0] IdFirstHigh = 8'd91;

  // Printable character range.
  localparam logic [ByteW-1:0] PrintLow  = 8'd32;
  localparam logic [ByteW-1:0] PrintHigh = 8'd126;

  // Header lengths and positions, counted from zero.
  localparam logic [CountW-1:0] HdrFlagPos    = 28'd5;
  localparam logic [CountW-1:0] HdrSizeFirst  = 28'd6;
  localparam logic [CountW-1:0] HdrSizeLast   = 28'd9;
  localparam logic [CountW-1:0] ExtSizeLast   = 28'd3;
  localparam logic [CountW-1:0] ExtSizeBytes  = 28'd4;
  localparam logic [CountW-1:0] FrIdBytes     = 28'd4;
  localparam logic [CountW-1:0] FrSizeEnd     = 28'd8;
  localparam logic [CountW-1:0] FrHdrLast     = 28'd10;

  // One result of the extractor.
  typedef struct packed {
    logic [IdW-1:0]   frame_tag;
    logic [ByteW-1:0] content_byte;
    logic             is_printable;
    logic             last_in_frame;
  } id3_result_t;

endpackage

// ----- rtl/core/id3v2_frame_extractor.sv -----
// ID3v2 tag parser that streams out the content bytes of selected frames.
//
//  Channel  Ports                        Payload (lowest bit first)
//  -------  ---------------------------  ------------------------------------------
//  input    s_tvalid s_tready s_tdata    s_tdata: data_byte[7:0]
//           s_tuser                      s_tuser: start_of_file
//  output   m_tvalid m_tready m_tdata    m_tdata: frame_tag[31:0], content_byte[39:32]
//           m_tuser m_tlast              m_tuser: is_printable; m_tlast: last_in_frame
//  config   cfg_we cfg_index cfg_wdata   index 0: select_mode, index 1: search_id
//
// One byte is accepted per cycle while s_tready is high; its parse step completes
// in that cycle, and any result is registered in the output register or the skid.
// The rate is set by the single parse-state update between the input handshake and
// the result register; a two-entry output (register plus skid) absorbs one stall.
// Reset (rst, synchronous) clears the parse state, the configuration and the output.
// While the output is stalled, requests that yield no result are still taken; the
// first one that yields a result fills the skid stage, and then s_tready drops.
module id3v2_frame_extractor
  import id3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Input byte stream.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [ByteW-1:0] s_tdata,   // data_byte[7:0]
  input  logic             s_tuser,   // start_of_file
  // Result stream.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OutW-1:0]  m_tdata,   // frame_tag[31:0], content_byte[39:32]
  output logic             m_tuser,   // is_printable
  output logic             m_tlast,   // last_in_frame
  // Configuration writes.
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [IdW-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_EXTSIZE,
    PH_EXTSKIP,
    PH_FRHDR,
    PH_CONTENT,
    PH_DONE
  } phase_t;

  // Configuration registers.
  logic           select_mode;
  logic [IdW-1:0] search_id;

  // Parse state.
  phase_t          phase, phase_next;
  logic [CountW-1:0] phase_count, phase_count_next;
  logic [RemW-1:0] tag_remaining, tag_remaining_next;
  logic [CountW-1:0] size_accum, size_accum_next;
  logic [IdW-1:0]  current_id, current_id_next;
  logic            ext_present, ext_present_next;
  logic            frame_selected, frame_selected_next;

  // Output register and skid stage.
  id3_result_t out_reg, skid_reg, res;
  logic        out_valid, skid_valid;
  logic        res_valid;
  logic        s_acc;

  assign s_tready = !skid_valid;
  assign s_acc    = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_reg.content_byte, out_reg.frame_tag};
  assign m_tuser  = out_reg.is_printable;
  assign m_tlast  = out_reg.last_in_frame;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode <= 1'b0;
      search_id   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgSelectMode: select_mode <= cfg_wdata[0];
        CfgSearchId:   search_id   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Parse step for one byte.
  always_comb begin
    logic [ByteW-1:0]  b;
    logic [CountW-1:0] acc_shift;
    logic [CountW-1:0] len;
    logic [ByteW-1:0]  first_ch;

    b        = s_tdata;
    first_ch = current_id[IdW-1 -: ByteW];

    phase_next          = phase;
    phase_count_next    = phase_count;
    tag_remaining_next  = tag_remaining;
    size_accum_next     = size_accum;
    current_id_next     = current_id;
    ext_present_next    = ext_present;
    frame_selected_next = frame_selected;
    res_valid           = 1'b0;
    acc_shift           = '0;
    len                 = '0;

    // A restart clears the parse state before this byte is handled.
    if (s_tuser) begin
      phase_next          = PH_HEADER;
      phase_count_next    = '0;
      tag_remaining_next  = '0;
      size_accum_next     = '0;
      current_id_next     = '0;
      ext_present_next    = 1'b0;
      frame_selected_next = 1'b0;
    end

    res.frame_tag     = current_id_next;
    res.content_byte  = b;
    res.is_printable  = (b >= PrintLow) && (b <= PrintHigh);
    res.last_in_frame = (phase_count_next <= CountW'(1));

    // Every byte after the tag header uses up one byte of the tag size, down to zero.
    if (phase_next != PH_HEADER && phase_next != PH_DONE &&
        tag_remaining_next != '0) begin
      tag_remaining_next = tag_remaining_next - RemW'(1);
    end

    unique case (phase_next)
      PH_HEADER: begin
        if (phase_count_next == HdrFlagPos) begin
          ext_present_next = (b & ExtHeaderFlag) != '0;
        end
        if (phase_count_next >= HdrSizeFirst) begin
          acc_shift = (phase_count_next == HdrSizeFirst) ? '0 : size_accum_next;
          size_accum_next = {acc_shift[CountW-8:0], b[6:0]};
        end
        if (phase_count_next >= HdrSizeLast) begin
          tag_remaining_next = RemW'(size_accum_next);
          phase_count_next   = '0;
          if (ext_present_next) begin
            phase_next = PH_EXTSIZE;
          end else begin
            phase_next = (tag_remaining_next != '0) ? PH_FRHDR : PH_DONE;
          end
        end else begin
          phase_count_next = phase_count_next + CountW'(1);
        end
      end
      PH_EXTSIZE: begin
        acc_shift = (phase_count_next == '0) ? '0 : size_accum_next;
        size_accum_next = {acc_shift[CountW-8:0], b[6:0]};
        if (phase_count_next >= ExtSizeLast) begin
          if (size_accum_next > ExtSizeBytes) begin
            phase_next       = PH_EXTSKIP;
            phase_count_next = size_accum_next - ExtSizeBytes;
          end else begin
            phase_next       = (tag_remaining_next != '0) ? PH_FRHDR : PH_DONE;
            phase_count_next = '0;
          end
        end else begin
          phase_count_next = phase_count_next + CountW'(1);
        end
      end
      PH_EXTSKIP: begin
        if (phase_count_next != '0) begin
          phase_count_next = phase_count_next - CountW'(1);
        end
        if (phase_count_next == '0) begin
          phase_next = (tag_remaining_next != '0) ? PH_FRHDR : PH_DONE;
        end
      end
      PH_FRHDR: begin
        if (phase_count_next < FrIdBytes) begin
          current_id_next = (phase_count_next == '0) ? IdW'(b)
                          : {current_id_next[IdW-ByteW-1:0], b};
        end else if (phase_count_next < FrSizeEnd) begin
          acc_shift = (phase_count_next == FrIdBytes) ? '0 : size_accum_next;
          size_accum_next = {acc_shift[CountW-8:0], b[6:0]};
        end
        if (phase_count_next >= FrHdrLast) begin
          len = (size_accum_next != '0) ? size_accum_next - CountW'(1) : '0;
          if (select_mode) begin
            frame_selected_next = (current_id_next == search_id);
          end else begin
            frame_selected_next = (current_id_next != IdApic) &&
                                  (first_ch >= IdFirstLow) && (first_ch <= IdFirstHigh);
          end
          if (len != '0) begin
            phase_next       = PH_CONTENT;
            phase_count_next = len;
          end else begin
            phase_next       = (tag_remaining_next != '0) ? PH_FRHDR : PH_DONE;
            phase_count_next = '0;
          end
        end else begin
          phase_count_next = phase_count_next + CountW'(1);
        end
      end
      PH_CONTENT: begin
        res_valid = frame_selected_next;
        if (phase_count_next != '0) begin
          phase_count_next = phase_count_next - CountW'(1);
        end
        if (phase_count_next == '0) begin
          phase_next = (tag_remaining_next != '0) ? PH_FRHDR : PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // Parse state registers, updated on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      phase_count    <= '0;
      tag_remaining  <= '0;
      size_accum     <= '0;
      current_id     <= '0;
      ext_present    <= 1'b0;
      frame_selected <= 1'b0;
    end else if (s_acc) begin
      phase          <= phase_next;
      phase_count    <= phase_count_next;
      tag_remaining  <= tag_remaining_next;
      size_accum     <= size_accum_next;
      current_id     <= current_id_next;
      ext_present    <= ext_present_next;
      frame_selected <= frame_selected_next;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s_acc && res_valid;
      end
    end else if (s_acc && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (s_acc && res_valid) begin
      skid_reg <= res;
    end
  end

  // The skid stage only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  // Reset leaves the parser at the tag header with no pending result.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (phase == PH_HEADER) && !out_valid && !skid_valid)
    else $error("reset did not clear parser and output");

  // A restart byte is tag header byte zero.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tuser) |=> (phase == PH_HEADER) && (phase_count == CountW'(1)))
    else $error("restart byte was not taken as the first header byte");

  // Content phase always has bytes left to read.
  a_content_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CONTENT) |-> (phase_count != '0))
    else $error("content phase with a zero byte count");

endmodule

// ----- bench/tb_id3v2_frame_extractor.sv -----
// Self-checking bench for the ID3v2 frame extractor: byte stream in, frame content out.
module tb_id3v2_frame_extractor
  import id3_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 300;

  typedef enum logic [2:0] {
    PhHeader, PhExtSize, PhExtSkip, PhFrHdr, PhContent, PhDone
  } parse_phase_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             sof;
  } file_byte_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [ByteW-1:0] s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OutW-1:0]  m_tdata;
  logic             m_tuser;
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [IdW-1:0]   cfg_wdata = '0;

  id3v2_frame_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bytes waiting to be offered, and content bytes still owed by the block.
  file_byte_t  file_bytes[$];
  id3_result_t expected_content[$];
  int unsigned bytes_planned = 0;
  int unsigned mismatches = 0;

  // Idling limits per side, and the request for one long receiver hold-off.
  int unsigned src_gap_max = 0;
  int unsigned sink_stall_max = 0;
  int unsigned src_wait = 0;
  int unsigned sink_wait = 0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  // Parse model state, at its reset values.
  parse_phase_t      phase = PhHeader;
  logic [CountW-1:0] ph_cnt = '0;
  logic [RemW-1:0]   tag_left = '0;
  logic [CountW-1:0] size_acc = '0;
  logic [IdW-1:0]    cur_id = '0;
  logic              has_ext = 1'b0;
  logic              fr_sel = 1'b0;
  logic              sel_mode = 1'b0;
  logic [IdW-1:0]    want_id = '0;

  // Shift one syncsafe size byte into the accumulator; the top bit is dropped.
  function automatic logic [CountW-1:0] next_syncsafe(input logic [ByteW-1:0] b,
                                                       input logic first);
    logic [CountW-1:0] prev;
    prev = first ? '0 : size_acc;
    return {prev[CountW-8:0], b[6:0]};
  endfunction

  // At the end of a section, carry on with frames while the tag still has bytes.
  task automatic close_section();
    phase  = (tag_left != '0) ? PhFrHdr : PhDone;
    ph_cnt = '0;
  endtask

  // Advance the parse model by one accepted byte and queue any content it yields.
  task automatic parse_byte(input logic [ByteW-1:0] b, input logic sof);
    id3_result_t       r;
    logic [CountW-1:0] skip_len;
    logic [CountW-1:0] body_len;
    if (sof) begin
      phase    = PhHeader;
      ph_cnt   = '0;
      tag_left = '0;
      size_acc = '0;
      cur_id   = '0;
      has_ext  = 1'b0;
      fr_sel   = 1'b0;
    end
    // Every byte past the tag header counts down the tag, stopping at zero.
    if (phase != PhHeader && phase != PhDone && tag_left != '0) tag_left--;
    case (phase)
      PhHeader: begin
        if (ph_cnt == HdrFlagPos) has_ext = (b & ExtHeaderFlag) != '0;
        if (ph_cnt >= HdrSizeFirst) size_acc = next_syncsafe(b, ph_cnt == HdrSizeFirst);
        if (ph_cnt >= HdrSizeLast) begin
          tag_left = {2'b00, size_acc};
          if (has_ext) begin
            phase  = PhExtSize;
            ph_cnt = '0;
          end else begin
            close_section();
          end
        end else begin
          ph_cnt++;
        end
      end
      PhExtSize: begin
        size_acc = next_syncsafe(b, ph_cnt == '0);
        if (ph_cnt >= ExtSizeLast) begin
          skip_len = (size_acc > ExtSizeBytes) ? size_acc - ExtSizeBytes : '0;
          if (skip_len != '0) begin
            phase  = PhExtSkip;
            ph_cnt = skip_len;
          end else begin
            close_section();
          end
        end else begin
          ph_cnt++;
        end
      end
      PhExtSkip: begin
        if (ph_cnt != '0) ph_cnt--;
        if (ph_cnt == '0) close_section();
      end
      PhFrHdr: begin
        if (ph_cnt < FrIdBytes) begin
          cur_id = {((ph_cnt == '0) ? 24'h0 : cur_id[23:0]), b};
        end else if (ph_cnt < FrSizeEnd) begin
          size_acc = next_syncsafe(b, ph_cnt == FrIdBytes);
        end
        if (ph_cnt >= FrHdrLast) begin
          body_len = (size_acc != '0) ? size_acc - CountW'(1) : '0;
          if (sel_mode) begin
            fr_sel = (cur_id == want_id);
          end else begin
            fr_sel = cur_id != IdApic && cur_id[31:24] >= IdFirstLow &&
                     cur_id[31:24] <= IdFirstHigh;
          end
          if (body_len != '0) begin
            phase  = PhContent;
            ph_cnt = body_len;
          end else begin
            close_section();
          end
        end else begin
          ph_cnt++;
        end
      end
      PhContent: begin
        if (fr_sel) begin
          r.frame_tag     = cur_id;
          r.content_byte  = b;
          r.is_printable  = (b >= PrintLow && b <= PrintHigh);
          r.last_in_frame = (ph_cnt <= CountW'(1));
          expected_content.push_back(r);
        end
        if (ph_cnt != '0) ph_cnt--;
        if (ph_cnt == '0) close_section();
      end
      default: begin
      end
    endcase
  endtask

  function automatic void log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
  endfunction

  // Sender: offers queued bytes, idling a drawn number of cycles between requests.
  always @(posedge clk) begin
    file_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait = 0;
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tuser);
      if ((s_tvalid && s_tready) || !s_tvalid) begin
        if (src_wait == 0 && file_bytes.size() != 0) begin
          nxt = file_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tuser  <= nxt.sof;
          src_wait = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
        end else begin
          s_tvalid <= 1'b0;
          if (src_wait != 0) src_wait--;
        end
      end
    end
  end

  // Receiver: checks each result request against the oldest expectation.
  always @(posedge clk) begin
    id3_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_content.size() == 0) begin
          log_mismatch($sformatf("unexpected result tag %h byte %h print %b last %b",
                                 m_tdata[IdW-1:0], m_tdata[OutW-1:IdW], m_tuser, m_tlast));
        end else begin
          want = expected_content.pop_front();
          if (m_tdata[IdW-1:0] !== want.frame_tag ||
              m_tdata[OutW-1:IdW] !== want.content_byte ||
              m_tuser !== want.is_printable || m_tlast !== want.last_in_frame) begin
            log_mismatch($sformatf({"expected tag %h byte %h print %b last %b, ",
                                    "got tag %h byte %h print %b last %b"},
                                   want.frame_tag, want.content_byte, want.is_printable,
                                   want.last_in_frame, m_tdata[IdW-1:0],
                                   m_tdata[OutW-1:IdW], m_tuser, m_tlast));
          end
        end
        sink_wait = (sink_stall_max == 0) ? 0 : $urandom_range(0, sink_stall_max);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        sink_wait = LongHold;
      end
      if (sink_wait != 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic sof = 1'b0);
    file_byte_t f;
    f.data = b;
    f.sof  = sof;
    file_bytes.push_back(f);
    bytes_planned++;
  endtask

  // Four syncsafe bytes, most significant first, with the ignored top bits random.
  task automatic send_syncsafe(input int unsigned v);
    for (int k = 3; k >= 0; k--) send_byte({1'($urandom), 7'(v >> (7 * k))});
  endtask

  task automatic send_tag_header(input int unsigned tag_size, input bit ext);
    logic [ByteW-1:0] flags;
    flags = 8'($urandom);
    flags[6] = ext;
    send_byte("I", 1'b1);
    send_byte("D");
    send_byte("3");
    send_byte(8'd3);
    send_byte(8'd0);
    send_byte(flags);
    send_syncsafe(tag_size);
  endtask

  task automatic send_ext(input int unsigned ext_size);
    send_syncsafe(ext_size);
    if (ext_size > 4) repeat (ext_size - 4) send_byte(8'($urandom));
  endtask

  task automatic send_frame_head(input logic [IdW-1:0] id, input int unsigned fr_size);
    for (int k = 3; k >= 0; k--) send_byte(id[8*k +: 8]);
    send_syncsafe(fr_size);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(8'($urandom_range(0, 3)));
  endtask

  function automatic logic [IdW-1:0] pick_frame_id();
    logic [ByteW-1:0] firsts[4] = '{8'd64, 8'd65, 8'd91, 8'd92};
    case ($urandom_range(0, 7))
      0: return "TIT2";
      1: return "TALB";
      2: return IdApic;
      3: return want_id;
      4: return "COMM";
      5: return "abcd";
      6: return {firsts[$urandom_range(0, 3)], 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // One tag: optional extended header, a few frames, and a size that may be
  // exact, short of the frames, or padded; then bytes past the tag, sometimes cut.
  task automatic send_file();
    logic [IdW-1:0] ids[4];
    int unsigned    sizes[4];
    int unsigned    nfr;
    int unsigned    ext_size;
    int unsigned    body;
    int unsigned    tag_size;
    bit             with_ext;
    nfr = $urandom_range(1, 4);
    with_ext = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 4))
      0: ext_size = 0;
      1: ext_size = 3;
      2: ext_size = 4;
      3: ext_size = 5;
      default: ext_size = 10;
    endcase
    body = with_ext ? 4 + ((ext_size > 4) ? ext_size - 4 : 0) : 0;
    for (int i = 0; i < nfr; i++) begin
      ids[i] = pick_frame_id();
      case ($urandom_range(0, 9))
        0: sizes[i] = 0;
        1: sizes[i] = 1;
        2: sizes[i] = $urandom_range(20, 40);
        default: sizes[i] = $urandom_range(2, 10);
      endcase
      body += 11 + ((sizes[i] > 1) ? sizes[i] - 1 : 0);
    end
    case ($urandom_range(0, 9))
      0: tag_size = $urandom_range(0, body);
      1, 2: tag_size = body + $urandom_range(1, 24);
      default: tag_size = body;
    endcase
    send_tag_header(tag_size, with_ext);
    if (with_ext) send_ext(ext_size);
    for (int i = 0; i < nfr; i++) begin
      send_frame_head(ids[i], sizes[i]);
      if (sizes[i] > 1) begin
        repeat (sizes[i] - 1) begin
          if ($urandom_range(0, 1) != 0) send_byte(8'($urandom_range(32, 126)));
          else send_byte(8'($urandom));
        end
      end
    end
    if (tag_size > body) repeat (tag_size - body) send_byte(8'h00);
    repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
    // A cut file is ended early by the restart of the next one.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        void'(file_bytes.pop_back());
        bytes_planned--;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [IdW-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgSelectMode) sel_mode = v[0];
    else want_id = v;
  endtask

  // Program both registers while idle and set the idling of both sides.
  task automatic configure(input logic mode, input logic [IdW-1:0] id,
                           input int unsigned gap, input int unsigned stall);
    logic [IdW-1:0] mode_word;
    mode_word = $urandom;
    mode_word[0] = mode;
    write_reg(CfgSelectMode, mode_word);
    write_reg(CfgSearchId, id);
    @(negedge clk);
    src_gap_max = gap;
    sink_stall_max = stall;
  endtask

  // Wait until every byte has gone in and every result has come out.
  task automatic settle();
    do @(negedge clk);
    while (file_bytes.size() != 0 || s_tvalid || expected_content.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Mostly well-formed tags, with bursts of noise and stray restarts.
  task automatic run_random(input int unsigned n);
    int unsigned first;
    first = bytes_planned;
    while (bytes_planned - first < n) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12))
          send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        send_file();
      end
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Show-all mode with registers at their reset values.
    configure(1'b0, 32'h0, 13, 13);
    // Edge content bytes, a skipped picture frame, an empty frame, bytes past the tag.
    send_tag_header(41, 1'b0);
    send_frame_head("TIT2", 7);
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(8'h20);
    send_byte(8'h7E);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_frame_head(IdApic, 3);
    send_byte("A");
    send_byte("B");
    send_frame_head("TPE1", 0);
    send_byte(8'hAA);
    send_byte(8'h55);
    // Short extended header, then first id characters just below and at both range ends.
    send_tag_header(40, 1'b1);
    send_ext(2);
    send_frame_head("@BCD", 2);
    send_byte("x");
    send_frame_head("[BCD", 2);
    send_byte("y");
    send_frame_head("ABCD", 2);
    send_byte("z");
    // Extended header with bytes to skip, a size-one frame and a one-byte frame.
    send_tag_header(29, 1'b1);
    send_ext(6);
    send_frame_head("ZZZZ", 1);
    send_frame_head("Z123", 2);
    send_byte(8'h80);
    // Empty tag: everything after the header is ignored.
    send_tag_header(0, 1'b0);
    send_byte("T");
    send_byte(8'hFF);
    run_random(60);

    configure(1'b1, "TIT2", 0, 0);
    run_random(80);

    // A long selected frame offered back to back while the receiver holds off.
    configure(1'b0, 32'hFFFF_FFFF, 0, 13);
    send_tag_header(71, 1'b0);
    send_frame_head("TXXX", 61);
    repeat (60) send_byte(8'($urandom_range(32, 126)));
    hold_request = 1'b1;
    run_random(80);

    configure(1'b1, 32'hFFFF_FFFF, 13, 0);
    run_random(80);

    configure(1'b1, 32'h0, 13, 13);
    run_random(80);

    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_content.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
